### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pwft_pkg.sv
// Shared constants and types of the pulse width frame transmitter.
`default_nettype none

package pwft_pkg;

    // Buffer geometry
    localparam int BUFFER_BYTES = 32;
    localparam int BUF_AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W        = $clog2(BUFFER_BYTES + 2);

    // Timing
    localparam int          UNIT_W     = 16;
    localparam int          BIT_W      = UNIT_W + 1;
    localparam int          INTV_W     = UNIT_W + 2;
    localparam logic [15:0] UNIT_RESET = 16'd427;

    // Request codes carried in the input sideband
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_SEND  = 2'd2
    } action_t;

    // Control from the sequencer to the byte buffer
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       clear;
    } buf_ctrl_t;

    // Status from the byte buffer
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       sum;
        logic             full;
        logic [7:0]       rd_data;
    } buf_stat_t;

endpackage

`default_nettype wire

### design/pwft_buffer.sv
// Frame byte buffer with fill count, running sum and registered read port.
`default_nettype none

module pwft_buffer
    import pwft_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire buf_ctrl_t        ctrl,
    input  wire logic [POS_W-1:0] rd_pos,
    output buf_stat_t             stat
);

    logic [7:0]       mem [BUFFER_BYTES];
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       rd_data_reg;
    logic [BUF_AW-1:0] rd_addr;

    // Hold an in-range address; past the end the data is never used
    assign rd_addr = (rd_pos < POS_W'(BUFFER_BYTES)) ? rd_pos[BUF_AW-1:0] : '0;

    // Append bytes at the fill count
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[count_reg[BUF_AW-1:0]] <= ctrl.wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Track fill count and byte sum; drop both when a frame completes
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (ctrl.wr_en) begin
            count_reg <= count_reg + CNT_W'(1);
            sum_reg   <= sum_reg + ctrl.wr_data;
        end
    end

    assign stat.count   = count_reg;
    assign stat.sum     = sum_reg;
    assign stat.full    = (count_reg == CNT_W'(BUFFER_BYTES));
    assign stat.rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/pulse_width_frame_transmitter.sv
// Pulse width frame transmitter: sequencer, output register and assertions.
// Takes one beat per clock: tick (tuser 0), store byte (tuser 1) or send (tuser 2),
// and returns one result beat for each in the cycle after acceptance, carrying
// the line level, whether the request was taken and whether a frame is busy.
// Every beat is handled combinationally between the state registers and
// the result register, so s_tready stays high unless a result waits on a
// stalled m_tready. A frame is 3 units of high line, a 2-unit start interval,
// then checksum and data bytes MSB first, 1 unit per zero and 1.5 per one,
// each interval closed by a toggle; time advances only on tick beats. The
// next buffered byte is prefetched by the buffer's registered read port,
// which has at least eight ticks to settle before it is needed.
`default_nettype none
`include "assert_macros.svh"

module pulse_width_frame_transmitter
    import pwft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration: unit_ticks
    input  wire logic              cfg_wr_en,
    input  wire logic [UNIT_W-1:0] cfg_wr_data,
    // request stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]        s_tuser,   // [1:0] action
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata    // [0] line_level, [1] accepted,
                                              // [2] busy_res, [7:3] zero
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SILENCE = 2'd1,
        PH_START   = 2'd2,
        PH_BITS    = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [UNIT_W-1:0]   unit_reg;
    logic [POS_W-1:0]    byte_pos_reg, byte_pos_next;
    logic [2:0]          bit_pos_reg, bit_pos_next;
    logic [INTV_W-1:0]   intv_reg, intv_next;
    logic [7:0]          shift_reg, shift_next;
    logic                line_reg, line_next;
    logic                acc;
    logic                in_fire;
    logic                m_valid_reg;
    logic [2:0]          m_data_reg;
    buf_ctrl_t           bctrl;
    buf_stat_t           bstat;
    logic [7:0]          checksum;
    logic [BIT_W-1:0]    zero_ticks;
    logic [BIT_W-1:0]    one_ticks;
    logic [POS_W-1:0]    byte_pos_inc;

    pwft_buffer u_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bctrl),
        .rd_pos  (byte_pos_reg),
        .stat    (bstat)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    assign checksum     = 8'd0 - bstat.sum;
    assign zero_ticks   = {1'b0, unit_reg};
    assign one_ticks    = {1'b0, unit_reg} + {2'b00, unit_reg[UNIT_W-1:1]};
    assign byte_pos_inc = byte_pos_reg + POS_W'(1);

    // Work out the next state for one accepted beat
    always_comb begin
        phase_next    = phase_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        intv_next     = intv_reg;
        shift_next    = shift_reg;
        line_next     = line_reg;
        acc           = 1'b0;
        bctrl.wr_en   = 1'b0;
        bctrl.wr_data = s_tdata;
        bctrl.clear   = 1'b0;

        if (in_fire) begin
            case (s_tuser)
                ACT_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        if (intv_reg > INTV_W'(1)) begin
                            intv_next = intv_reg - INTV_W'(1);
                        end else begin
                            // close the interval with a toggle
                            line_next = !line_reg;
                            case (phase_reg)
                                PH_SILENCE: begin
                                    phase_next = PH_START;
                                    intv_next  = {1'b0, unit_reg, 1'b0};
                                end
                                PH_START: begin
                                    phase_next    = PH_BITS;
                                    byte_pos_next = '0;
                                    bit_pos_next  = '0;
                                    shift_next    = checksum;
                                    intv_next     = INTV_W'(checksum[7] ? one_ticks
                                                                        : zero_ticks);
                                end
                                default: begin
                                    bit_pos_next = bit_pos_reg + 3'd1;
                                    if (bit_pos_reg == 3'd7) begin
                                        byte_pos_next = byte_pos_inc;
                                        if (byte_pos_inc > POS_W'(bstat.count)) begin
                                            // frame done: release line and buffer
                                            phase_next    = PH_IDLE;
                                            byte_pos_next = '0;
                                            bit_pos_next  = '0;
                                            intv_next     = '0;
                                            line_next     = 1'b1;
                                            bctrl.clear   = 1'b1;
                                        end else begin
                                            shift_next = bstat.rd_data;
                                            intv_next  = INTV_W'(bstat.rd_data[7]
                                                                 ? one_ticks : zero_ticks);
                                        end
                                    end else begin
                                        shift_next = {shift_reg[6:0], 1'b0};
                                        intv_next  = INTV_W'(shift_reg[6] ? one_ticks
                                                                          : zero_ticks);
                                    end
                                end
                            endcase
                        end
                    end
                end
                ACT_STORE: begin
                    if (phase_reg == PH_IDLE && !bstat.full) begin
                        bctrl.wr_en = 1'b1;
                        acc         = 1'b1;
                    end
                end
                ACT_SEND: begin
                    if (phase_reg == PH_IDLE) begin
                        phase_next    = PH_SILENCE;
                        byte_pos_next = '0;
                        bit_pos_next  = '0;
                        intv_next     = {1'b0, unit_reg, 1'b0} + {2'b00, unit_reg};
                        acc           = 1'b1;
                    end
                end
                default: begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    // Hold sequencer state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            byte_pos_reg <= '0;
            bit_pos_reg  <= '0;
            intv_reg     <= '0;
            line_reg     <= 1'b1;
            unit_reg     <= UNIT_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg  <= bit_pos_next;
            intv_reg     <= intv_next;
            line_reg     <= line_next;
            if (cfg_wr_en) begin
                unit_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (in_fire) begin
            m_data_reg <= {(phase_next != PH_IDLE), acc, line_next};
        end
    end

    `ASSERT_ALWAYS(a_idle_line_high, aclk, aresetn, (phase_reg != PH_IDLE) || line_reg, "line low while idle")
    `ASSERT_ALWAYS(a_bitpos_outside_bits, aclk, aresetn, (phase_reg == PH_BITS) || (bit_pos_reg == 3'd0), "bit position moved outside bit phase")
    `ASSERT_NEXT(a_send_starts_frame, aclk, aresetn, in_fire && (s_tuser == ACT_SEND) && (phase_reg == PH_IDLE), (phase_reg == PH_SILENCE) && m_tvalid && m_tdata[2], "send request did not start frame")

endmodule

`default_nettype wire

### dv/pulse_width_frame_transmitter_tb.sv
// Self-checking testbench for the pulse width frame transmitter.
`timescale 1ns / 1ps

module pulse_width_frame_transmitter_tb;
    import pwft_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;   // no request code, block must ignore it

    // Result bits {busy, accepted, line}
    localparam logic [2:0] R_IDLE     = 3'b001;
    localparam logic [2:0] R_STORED   = 3'b011;
    localparam logic [2:0] R_SENT     = 3'b111;
    localparam logic [2:0] R_REFUSED  = 3'b101;
    localparam logic [2:0] R_BUSY_LOW = 3'b100;

    localparam int RANDOM_ITEMS     = 450;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT      = 2000;
    localparam int PRINT_LIMIT      = 50;
    localparam int NO_LIMIT         = 32'h7fffffff;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SILENCE = 2'd1,
        PH_START   = 2'd2,
        PH_BITS    = 2'd3
    } tx_phase_e;

    typedef enum logic {
        ROW_BEAT = 1'b0,
        ROW_UNIT = 1'b1
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  act;
        logic [15:0] value;   // data byte, or unit ticks on a ROW_UNIT row
        logic        typed;
        logic [2:0]  want;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [22] = '{
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b1, R_IDLE},
        '{ROW_BEAT, ACT_IGNORED, 16'h00ff, 1'b1, R_IDLE},
        // zero-length unit: every interval still takes one tick
        '{ROW_UNIT, ACT_TICK,    16'd0,    1'b0, 3'b000},
        '{ROW_BEAT, ACT_SEND,    16'h0000, 1'b1, R_SENT},      // empty buffer, checksum only
        '{ROW_BEAT, ACT_SEND,    16'h0055, 1'b1, R_REFUSED},
        '{ROW_BEAT, ACT_STORE,   16'h00aa, 1'b1, R_REFUSED},
        '{ROW_BEAT, ACT_IGNORED, 16'h0000, 1'b1, R_REFUSED},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b1, R_BUSY_LOW},  // silence ends
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b0, 3'b000},
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b1, R_IDLE},      // last bit closes the frame
        '{ROW_BEAT, ACT_TICK,    16'h0000, 1'b1, R_IDLE},
        '{ROW_UNIT, ACT_TICK,    16'd1,    1'b0, 3'b000},
        '{ROW_BEAT, ACT_STORE,   16'h0000, 1'b1, R_STORED},
        '{ROW_BEAT, ACT_STORE,   16'h00ff, 1'b1, R_STORED},
        '{ROW_BEAT, ACT_SEND,    16'h0000, 1'b1, R_SENT}
    };

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [UNIT_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = 8'h00;
    logic [1:0]        s_tuser     = ACT_TICK;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [7:0]        m_tdata;

    // Frame predictor state
    logic [15:0] tx_unit;
    logic [7:0]  tx_buf [BUFFER_BYTES];
    int unsigned tx_count;
    logic [7:0]  tx_sum;
    logic        tx_sending;
    tx_phase_e   tx_phase;
    int unsigned tx_bytepos;
    int unsigned tx_bitpos;
    int unsigned tx_left;
    logic        tx_line;

    logic [2:0] frame_results [$];
    int items_accepted  = 0;
    int results_checked = 0;
    int work_items      = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    bit src_gaps_on    = 1'b0;
    bit sink_stalls_on = 1'b0;
    int holds_asked    = 0;
    int holds_taken    = 0;
    int hold_left      = 0;
    int stall_left     = 0;

    pulse_width_frame_transmitter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Length of the bit interval at the current frame position
    function automatic int unsigned bit_ticks();
        logic [7:0] frame_byte;
        frame_byte = (tx_bytepos == 0) ? 8'(8'h00 - tx_sum) : tx_buf[tx_bytepos - 1];
        if (frame_byte[7 - tx_bitpos])
            return 32'(tx_unit) + 32'(tx_unit) / 2;
        return 32'(tx_unit);
    endfunction

    // Toggle the line and load the next interval, or close the frame
    function automatic void close_interval();
        tx_line = ~tx_line;
        case (tx_phase)
            PH_SILENCE: begin
                tx_phase = PH_START;
                tx_left  = 2 * 32'(tx_unit);
            end
            PH_START: begin
                tx_phase   = PH_BITS;
                tx_bytepos = 0;
                tx_bitpos  = 0;
                tx_left    = bit_ticks();
            end
            default: begin
                tx_bitpos++;
                if (tx_bitpos >= 8) begin
                    tx_bitpos = 0;
                    tx_bytepos++;
                end
                if (tx_bytepos > tx_count) begin
                    tx_sending = 1'b0;
                    tx_phase   = PH_IDLE;
                    tx_bytepos = 0;
                    tx_bitpos  = 0;
                    tx_left    = 0;
                    tx_count   = 0;
                    tx_sum     = 8'h00;
                    tx_line    = 1'b1;
                end else begin
                    tx_left = bit_ticks();
                end
            end
        endcase
    endfunction

    // Apply one request, return {busy, accepted, line}
    function automatic logic [2:0] frame_step(logic [1:0] act, logic [7:0] data);
        logic taken;
        taken = 1'b0;
        case (act)
            ACT_TICK: begin
                if (tx_sending) begin
                    if (tx_left > 1)
                        tx_left--;
                    else
                        close_interval();
                end
            end
            ACT_STORE: begin
                if (!tx_sending && tx_count < BUFFER_BYTES) begin
                    tx_buf[tx_count] = data;
                    tx_count++;
                    tx_sum = tx_sum + data;
                    taken  = 1'b1;
                end
            end
            ACT_SEND: begin
                if (!tx_sending) begin
                    tx_sending = 1'b1;
                    tx_phase   = PH_SILENCE;
                    tx_bytepos = 0;
                    tx_bitpos  = 0;
                    tx_left    = 3 * 32'(tx_unit);
                    taken      = 1'b1;
                end
            end
            default: ;
        endcase
        return {tx_sending, taken, tx_line};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %02h, expected %02h (result %0d)",
                     $realtime, what, got, exp, results_checked);
        mismatches++;
    endtask

    // Offer one beat, hold it until taken, then queue its expected result
    task automatic send_item(input logic [1:0] act, input logic [7:0] data,
                             input logic typed, input logic [2:0] want);
        int gap;
        logic [2:0] predicted;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = frame_step(act, data);
        frame_results.push_back(typed ? want : predicted);
        items_accepted++;
        if (act != ACT_IGNORED)
            work_items++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_checked < items_accepted) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_unit(input logic [15:0] ticks);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tx_unit = ticks;
    endtask

    function automatic logic [1:0] stray_action();
        case ($urandom_range(0, 2))
            0:       return ACT_STORE;
            1:       return ACT_SEND;
            default: return ACT_IGNORED;
        endcase
    endfunction

    // Tick until the frame ends or the limit runs out, with stray requests mixed in
    task automatic tick_until_idle(input int limit);
        int n;
        n = 0;
        while (tx_sending && n < limit) begin
            if ($urandom_range(0, 11) == 0)
                send_item(stray_action(), 8'($urandom), 1'b0, 3'b000);
            else
                send_item(ACT_TICK, 8'($urandom), 1'b0, 3'b000);
            n++;
        end
    endtask

    // Store bytes while idle; idle ticks and ignored codes are mixed in
    task automatic store_bytes(input int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_item($urandom_range(0, 1) ? ACT_TICK : ACT_IGNORED,
                          8'($urandom), 1'b0, 3'b000);
            send_item(ACT_STORE, 8'($urandom), 1'b0, 3'b000);
        end
    endtask

    function automatic logic [15:0] pick_unit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'($urandom_range(0, 1));
        if (r < 70) return 16'($urandom_range(2, 4));
        if (r < 90) return 16'($urandom_range(5, 12));
        return 16'($urandom_range(13, 40));
    endfunction

    // Result sink: random stalls plus the requested long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            m_tready    <= 1'b0;
            hold_left   <= SINK_HOLD_CYCLES - 1;
            holds_taken <= holds_taken + 1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 8'h00);
            end else begin
                want = frame_results.pop_front();
                if (m_tdata[0] !== want[0])
                    report_mismatch("line_level", {7'd0, m_tdata[0]}, {7'd0, want[0]});
                if (m_tdata[1] !== want[1])
                    report_mismatch("accepted", {7'd0, m_tdata[1]}, {7'd0, want[1]});
                if (m_tdata[2] !== want[2])
                    report_mismatch("busy_res", {7'd0, m_tdata[2]}, {7'd0, want[2]});
                if (m_tdata[7:3] !== 5'd0)
                    report_mismatch("tdata padding", {3'd0, m_tdata[7:3]}, 8'h00);
            end
            results_checked++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int base;
        int phase_no;
        bit filled;

        tx_unit    = UNIT_RESET;
        tx_count   = 0;
        tx_sum     = 8'h00;
        tx_sending = 1'b0;
        tx_phase   = PH_IDLE;
        tx_bytepos = 0;
        tx_bitpos  = 0;
        tx_left    = 0;
        tx_line    = 1'b1;
        filled     = 1'b0;
        phase_no   = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_UNIT) begin
                drain_results();
                write_unit(DIRECTED_ROWS[i].value);
            end else begin
                send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].value[7:0],
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        // Random phases, each with its own unit and idling mix
        base = work_items;
        while (work_items - base < RANDOM_ITEMS) begin
            drain_results();
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 0 && !filled) begin
                // fill the buffer past its end, then send the longest frame
                write_unit(16'd1);
                tick_until_idle(NO_LIMIT);
                store_bytes(BUFFER_BYTES + 2);
                send_item(ACT_SEND, 8'($urandom), 1'b0, 3'b000);
                tick_until_idle(NO_LIMIT);
                filled = 1'b1;
            end else begin
                write_unit(pick_unit());
                if (phase_no == 1)
                    holds_asked++;
                repeat ($urandom_range(1, 2)) begin
                    if (!tx_sending) begin
                        case ($urandom_range(0, 19))
                            0:       store_bytes($urandom_range(6, 10));
                            1, 2, 3: store_bytes($urandom_range(3, 5));
                            default: store_bytes($urandom_range(0, 2));
                        endcase
                        send_item(ACT_SEND, 8'($urandom), 1'b0, 3'b000);
                    end
                    // sometimes leave the frame running into the next unit
                    tick_until_idle(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                                 : NO_LIMIT);
                end
            end
            phase_no++;
        end

        // Largest unit: start a frame and tick into its long silence
        drain_results();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        tick_until_idle(NO_LIMIT);
        drain_results();
        write_unit(16'hffff);
        send_item(ACT_STORE, 8'h5a, 1'b0, 3'b000);
        send_item(ACT_SEND, 8'h00, 1'b0, 3'b000);
        tick_until_idle(100);

        drain_results();
        repeat (8) @(posedge aclk);
        if (frame_results.size() != 0)
            report_mismatch("expected result never arrived", 8'h00, {5'd0, frame_results[0]});
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pwft_pkg.sv
design/pwft_buffer.sv
design/pulse_width_frame_transmitter.sv
dv/pulse_width_frame_transmitter_tb.sv
